FILE: rtl/core/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared types and constants for the run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP   = 2'd0,
    CFG_TOTAL = 2'd1
  } cfg_idx_e;

  localparam logic [2:0]  BPP_RESET   = 3'd3;
  localparam logic [2:0]  BPP_BGRA    = 3'd4;
  localparam logic [31:0] TOTAL_RESET = 32'd1;

  // Packet header: top bit set marks a run packet.
  localparam int unsigned PKT_RUN_BIT = 7;
  localparam logic [7:0]  RUN_BIAS    = 8'd127;

  typedef struct packed {
    logic [2:0]  bpp;
    logic [31:0] pixel_total;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic       image_done;
    logic       clipped;
  } pix_res_t;

endpackage

FILE: rtl/core/tgarle_ifs.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder channel interfaces
// Byte input channel, pixel result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface tgarle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tgarle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] alpha;
  logic [7:0] repeat_res;
  logic       image_done;
  logic       clipped;

  modport source (output valid, output blue, output green, output red, output alpha,
                  output repeat_res, output image_done, output clipped, input ready);
  modport sink   (input valid, input blue, input green, input red, input alpha,
                  input repeat_res, input image_done, input clipped, output ready);
endinterface

interface tgarle_cfg_if;
  import tgarle_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/tgarle_cfg.sv
// ----------------------------------------------------------------------------
// TGA RLE configuration registers
// Holds the pixel format and the image size written over the config channel.
// ----------------------------------------------------------------------------
module tgarle_cfg (
  input  logic               clk,
  input  logic               rst,
  tgarle_cfg_if.sink         cfg,
  output tgarle_pkg::cfg_t   regs
);
  import tgarle_pkg::*;

  logic [2:0]  bpp;
  logic [31:0] pixel_total;

  // Writes are always taken at once.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp         <= BPP_RESET;
      pixel_total <= TOTAL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BPP:   bpp         <= cfg.data[2:0];
        CFG_TOTAL: pixel_total <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  assign regs.bpp         = bpp;
  assign regs.pixel_total = pixel_total;

endmodule

FILE: rtl/core/tgarle_core.sv
// ----------------------------------------------------------------------------
// TGA RLE decode core
// Packet and pixel state machine; produces at most one result per byte.
// ----------------------------------------------------------------------------
module tgarle_core (
  input  logic                 clk,
  input  logic                 rst,
  input  tgarle_pkg::cfg_t     regs,
  input  logic                 fire,
  input  logic [7:0]           data_byte,
  output logic                 res_valid,
  output tgarle_pkg::pix_res_t res
);
  import tgarle_pkg::*;

  logic        expect_header, expect_header_next;
  logic        run_packet, run_packet_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [23:0] color_hold, color_hold_next;
  logic [31:0] pixels_done, pixels_done_next;

  always_comb begin
    logic        four;
    logic [1:0]  last;
    logic [32:0] diff;
    logic        complete;
    logic [31:0] remaining;
    logic        rem_big;
    logic [7:0]  pl_eff;
    logic [7:0]  rep;
    logic        clip;
    logic [23:0] color_out;
    logic [7:0]  alpha;

    four      = (regs.bpp == BPP_BGRA);
    last      = four ? 2'd3 : 2'd2;
    diff      = {1'b0, regs.pixel_total} - {1'b0, pixels_done};
    complete  = diff[32] || (diff[31:0] == 32'd0);
    remaining = diff[31:0];
    rem_big   = |remaining[31:8];
    pl_eff    = (packet_left == 8'd0) ? 8'd1 : packet_left;

    expect_header_next = expect_header;
    run_packet_next    = run_packet;
    packet_left_next   = packet_left;
    byte_in_pixel_next = byte_in_pixel;
    color_hold_next    = color_hold;
    pixels_done_next   = pixels_done;
    res_valid          = 1'b0;

    // Completing-byte results, used only when a pixel finishes.
    color_out = color_hold;
    if (byte_in_pixel == 2'd2) begin
      color_out[23:16] = data_byte;
    end
    alpha = (byte_in_pixel != 2'd2 && four) ? data_byte : 8'd0;

    if (run_packet) begin
      if (!rem_big && (pl_eff > remaining[7:0])) begin
        rep  = remaining[7:0];
        clip = 1'b1;
      end else begin
        rep  = pl_eff;
        clip = 1'b0;
      end
    end else begin
      rep  = 8'd1;
      clip = (remaining == 32'd1) && (pl_eff > 8'd1);
    end

    if (fire && !complete) begin
      if (expect_header) begin
        run_packet_next    = data_byte[PKT_RUN_BIT];
        packet_left_next   = data_byte[PKT_RUN_BIT] ? (data_byte - RUN_BIAS)
                                                    : (data_byte + 8'd1);
        expect_header_next = 1'b0;
        byte_in_pixel_next = 2'd0;
      end else if (byte_in_pixel < last) begin
        case (byte_in_pixel)
          2'd0:    color_hold_next[7:0]   = data_byte;
          2'd1:    color_hold_next[15:8]  = data_byte;
          default: color_hold_next[23:16] = data_byte;
        endcase
        byte_in_pixel_next = byte_in_pixel + 2'd1;
      end else begin
        color_hold_next    = color_out;
        byte_in_pixel_next = 2'd0;
        pixels_done_next   = pixels_done + {24'd0, rep};
        res_valid          = 1'b1;
        if (run_packet) begin
          packet_left_next   = 8'd0;
          expect_header_next = 1'b1;
        end else begin
          packet_left_next   = pl_eff - 8'd1;
          expect_header_next = (pl_eff == 8'd1);
        end
      end
    end

    res.blue       = color_out[7:0];
    res.green      = color_out[15:8];
    res.red        = color_out[23:16];
    res.alpha      = alpha;
    res.repeat_res = rep;
    // The image ends exactly when this count uses up what was left.
    res.image_done = ({24'd0, rep} == remaining);
    res.clipped    = clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      packet_left   <= 8'd0;
      byte_in_pixel <= 2'd0;
      color_hold    <= 24'd0;
      pixels_done   <= 32'd0;
    end else begin
      expect_header <= expect_header_next;
      run_packet    <= run_packet_next;
      packet_left   <= packet_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      color_hold    <= color_hold_next;
      pixels_done   <= pixels_done_next;
    end
  end

endmodule

FILE: rtl/core/tgarle_outbuf.sv
// ----------------------------------------------------------------------------
// TGA RLE result buffer
// Output register plus one skid entry between the decode core and the sink.
// ----------------------------------------------------------------------------
module tgarle_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tgarle_pkg::pix_res_t res,
  output logic                 space,
  tgarle_pix_if.source         pixels
);
  import tgarle_pkg::*;

  logic     out_valid;
  pix_res_t out_data;
  logic     skid_valid;
  pix_res_t skid_data;
  logic     pop;

  assign pop   = out_valid && pixels.ready;
  // A push can only arrive while the skid entry is empty.
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (pop || !out_valid) begin
      out_data <= res;
    end
    if (!pop && out_valid && push) begin
      skid_data <= res;
    end
  end

  assign pixels.valid      = out_valid;
  assign pixels.blue       = out_data.blue;
  assign pixels.green      = out_data.green;
  assign pixels.red        = out_data.red;
  assign pixels.alpha      = out_data.alpha;
  assign pixels.repeat_res = out_data.repeat_res;
  assign pixels.image_done = out_data.image_done;
  assign pixels.clipped    = out_data.clipped;

endmodule

FILE: rtl/core/tga_rle_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes a run-length-encoded truecolor byte stream into pixel results.
// ----------------------------------------------------------------------------
// Usage:
//   The bytes channel takes the image-data stream, one byte per transaction,
//   starting with a packet header. The pixels channel delivers one transaction
//   per decoded pixel value: blue, green, red, alpha (zero for 3-byte pixels),
//   the number of consecutive pixels sharing it, a flag on the transaction
//   that completes the image, and a flag when a packet was cut at the image
//   end. Header bytes and the leading bytes of a pixel produce no transaction.
//   The cfg channel writes bytes_per_pixel (index 0) and pixel_total
//   (index 1); it is always ready and should only be used while idle.
//   One byte is accepted every cycle while the skid entry is free. A pixel
//   completed by a byte goes to the pixels channel through the single result
//   register after the decode logic, or the skid entry while the receiver stalls.
//   When the receiver stalls, the result register holds its transaction and a
//   one-entry skid buffer absorbs the next result; bytes keep flowing until
//   that skid entry is occupied, then bytes.ready drops until it drains.
//   Once the image is complete, further bytes are accepted and discarded.
//   Reset clears the decode state (awaiting a header, no pixels done), the
//   buffered results, and restores 3 bytes per pixel and a one-pixel image.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top (
  input  logic         clk,
  input  logic         rst,
  tgarle_cfg_if.sink   cfg,
  tgarle_byte_if.sink  bytes,
  tgarle_pix_if.source pixels
);
  import tgarle_pkg::*;

  cfg_t     regs;
  logic     space;
  logic     fire;
  logic     res_valid;
  pix_res_t res;

  // Configuration registers.
  tgarle_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // A byte is taken whenever the result buffer can absorb a result.
  assign bytes.ready = space;
  assign fire        = bytes.valid && space;

  // Packet and pixel decode; all work for a byte is done in its cycle.
  tgarle_core u_core (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .fire      (fire),
    .data_byte (bytes.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register and skid entry facing the receiver.
  tgarle_outbuf u_outbuf (
    .clk    (clk),
    .rst    (rst),
    .push   (res_valid),
    .res    (res),
    .space  (space),
    .pixels (pixels)
  );

endmodule
